// File: rtl/wsts_pkg.sv
// package for the work stealing task scheduler: types, codes and sizes
`timescale 1ns / 1ps
package wsts_pkg;

  localparam int NUM_WORKERS_DEF = 8;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int RUN_MAX = 15;

  typedef enum logic [1:0] {
    CMD_SUBMIT   = 2'd0,
    CMD_TAKE     = 2'd1,
    CMD_COMPLETE = 2'd2,
    CMD_STOP     = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_STOPPING = 3'd2,
    ST_FULL     = 3'd3,
    ST_NONE     = 3'd4,
    ST_EXIT     = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_READ,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] task_handle;
    logic        from_worker;
    logic [2:0]  worker;
  } sched_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] granted_handle;
    logic [2:0]  queue_used;
    logic        was_stolen;
    logic [7:0]  queued_total;
    logic [3:0]  active_total;
    logic        idle;
  } sched_out_t;

endpackage

// File: rtl/work_stealing_task_scheduler.sv
// top level of the work stealing task scheduler
//
// command port: start with cmd_in is taken when busy is low; busy then stays
// high through the cycle of the result strobe. result lands on result with
// done high for exactly one cycle; the receiver cannot stall it.
// submit, complete and stop go through decide to done. a take that finds its own
// queue non-empty goes through decide and read to done; a steal walks the other
// queues one per cycle from worker+1 with wrap, then reads from the first
// non-empty one, if any. the next start is taken in the cycle after done, so one
// transaction ends before the next begins.
// the single job store memory port (registered read) and the
// one-queue-per-cycle victim scan set this sequence of states.
// cfg_we writes workers_in_use (reset value 8); write it only while idle.
// rst clears all pointers, fills, counts and the stop flag; the job store
// itself needs no clearing since only written slots are read.
`timescale 1ns / 1ps
module work_stealing_task_scheduler #(
  parameter int NUM_WORKERS = wsts_pkg::NUM_WORKERS_DEF,
  parameter int QUEUE_DEPTH = wsts_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  wsts_pkg::sched_in_t  cmd_in,
  output logic                 busy,
  output logic                 done,
  output wsts_pkg::sched_out_t result,
  input  logic                 cfg_we,
  input  logic [3:0]           cfg_data
);
  import wsts_pkg::*;

  localparam int WB = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;
  localparam int SB = $clog2(QUEUE_DEPTH);
  localparam int FB = $clog2(QUEUE_DEPTH + 1);
  localparam int AB = WB + SB;
  localparam int CB = $clog2(NUM_WORKERS + 1);
  localparam int TB = $clog2(NUM_WORKERS * QUEUE_DEPTH + 1);

  state_t state, state_next;

  logic [SB-1:0] head [NUM_WORKERS];
  logic [FB-1:0] fill [NUM_WORKERS];
  logic [WB-1:0] rr;
  logic [TB-1:0] waiting;
  logic [3:0]    running;
  logic          stopping;
  logic [3:0]    cfg_reg;

  sched_in_t     req;
  logic [WB-1:0] q;        // queue under work
  logic [CB-1:0] n_lanes;
  logic [CB-1:0] scan_cnt;
  logic          stolen;
  logic          w_ok;
  logic [2:0]    status_r;
  logic [CB-1:0] cw;

  // lane count from the register, clamped to 1..NUM_WORKERS
  always_comb begin
    if (cfg_reg == 4'd0) begin
      n_lanes = CB'(1);
    end else if (32'(cfg_reg) > NUM_WORKERS) begin
      n_lanes = CB'(NUM_WORKERS);
    end else begin
      n_lanes = CB'(cfg_reg);
    end
  end

  assign cw   = (WB >= 3) ? CB'(req.worker) : CB'(req.worker);
  assign w_ok = (32'(req.worker) < 32'(n_lanes));

  // shared slot address unit
  logic [SB:0]   slot_sum;
  logic [SB-1:0] slot;
  logic          ram_we;
  logic [AB-1:0] ram_addr;
  logic [31:0]   ram_rdata;
  logic [FB-1:0] fill_q;
  logic [FB-1:0] fill_m1;

  assign fill_q  = fill[q];
  assign fill_m1 = fill_q - FB'(1);
  always_comb begin
    if (req.cmd == CMD_SUBMIT) begin
      slot_sum = (SB+1)'(head[q]) + (SB+1)'(fill_q);
    end else if (stolen) begin
      slot_sum = (SB+1)'(head[q]);
    end else begin
      slot_sum = (SB+1)'(head[q]) + (SB+1)'(fill_m1);
    end
    if (slot_sum >= (SB+1)'(QUEUE_DEPTH)) begin
      slot = SB'(slot_sum - (SB+1)'(QUEUE_DEPTH));
    end else begin
      slot = SB'(slot_sum);
    end
  end

  assign ram_addr = (AB)'(q) * AB'(QUEUE_DEPTH) + AB'(slot);

  wsts_ram #(.WIDTH(32), .DEPTH(NUM_WORKERS * QUEUE_DEPTH)) u_store (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(req.task_handle),
    .rdata(ram_rdata)
  );

  // round robin choice for the submit
  logic [WB-1:0] rr_q;
  logic [CB-1:0] rr_inc;
  assign rr_q   = (32'(rr) < 32'(n_lanes)) ? rr : WB'(0);
  assign rr_inc = CB'(rr_q) + CB'(1);

  // next victim in the scan
  logic [CB-1:0] q_inc;
  assign q_inc = CB'(q) + CB'(1);

  logic decide_take_own;
  assign decide_take_own = w_ok && (fill[req.worker[WB-1:0]] != '0);

  // accepted submit: queue and status are settled in the done cycle
  logic sub_go;
  assign sub_go = (state == S_DONE) && req.cmd == CMD_SUBMIT && status_r == ST_OK;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (req.cmd == CMD_TAKE) begin
          if (decide_take_own) state_next = S_READ;
          else if (w_ok && n_lanes > CB'(1)) state_next = S_SCAN;
          else state_next = S_DONE;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SCAN: begin
        if (fill_q != '0) state_next = S_READ;
        else if (scan_cnt <= CB'(1)) state_next = S_DONE;
      end
      S_READ:  state_next = S_DONE;
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy   = (state != S_IDLE);
    done   = (state == S_DONE);
    ram_we = sub_go;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      rr       <= '0;
      waiting  <= '0;
      running  <= '0;
      stopping <= 1'b0;
      cfg_reg  <= 4'd8;
      for (int i = 0; i < NUM_WORKERS; i++) begin
        head[i] <= '0;
        fill[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (cfg_we) cfg_reg <= cfg_data;
      case (state)
        S_IDLE: begin
          if (start) begin
            req      <= cmd_in;
            stolen   <= 1'b0;
            status_r <= ST_OK;
            q        <= '0;
          end
        end
        S_DECIDE: begin
          case (req.cmd)
            CMD_SUBMIT: begin
              if (req.task_handle == '0) begin
                status_r <= ST_EMPTY;
              end else begin
                if (req.from_worker && w_ok) begin
                  q <= req.worker[WB-1:0];
                end else begin
                  q  <= rr_q;
                  rr <= (rr_inc >= n_lanes) ? WB'(0) : WB'(rr_inc);
                end
                if (stopping) status_r <= ST_STOPPING;
                else if (fill[(req.from_worker && w_ok) ? req.worker[WB-1:0] : rr_q]
                         >= FB'(QUEUE_DEPTH)) status_r <= ST_FULL;
              end
            end
            CMD_TAKE: begin
              if (decide_take_own) begin
                q <= req.worker[WB-1:0];
              end else begin
                q <= (cw + CB'(1) >= n_lanes) ? WB'(cw + CB'(1) - n_lanes)
                                                : WB'(cw + CB'(1));
                scan_cnt <= n_lanes - CB'(1);
                stolen   <= 1'b1;
              end
            end
            CMD_COMPLETE: begin
              if (running != 4'd0) running <= running - 4'd1;
            end
            default: stopping <= 1'b1;
          endcase
        end
        S_SCAN: begin
          if (fill_q == '0) begin
            q        <= (q_inc >= n_lanes) ? WB'(0) : WB'(q_inc);
            scan_cnt <= scan_cnt - CB'(1);
            if (scan_cnt <= CB'(1)) stolen <= 1'b0;
          end
        end
        S_READ: begin
          // address uses pre-update head and fill; rdata valid next cycle
          if (stolen) begin
            head[q] <= (32'(head[q]) + 1 >= QUEUE_DEPTH) ? SB'(0) : head[q] + SB'(1);
          end
          fill[q] <= fill_m1;
          if (running != 4'(RUN_MAX)) running <= running + 4'd1;
          if (waiting != '0) waiting <= waiting - TB'(1);
          status_r <= ST_OK;
          req.from_worker <= 1'b1; // sets from_worker after a grant; the result does not use it
        end
        default: ;
      endcase
      if (sub_go) begin
        fill[q] <= fill_q + FB'(1);
        waiting <= waiting + TB'(1);
      end
    end
  end

  // the store is written and read in one place: drive the port directly
  logic rd_stage;
  always_ff @(posedge clk) begin
    if (rst) rd_stage <= 1'b0;
    else     rd_stage <= (state == S_READ);
  end

  // result assembly
  sched_out_t res;
  logic [TB-1:0] waiting_after;
  logic          granted_ok;
  assign waiting_after = sub_go ? waiting + TB'(1) : waiting;
  assign granted_ok    = (req.cmd == CMD_TAKE) && rd_stage;
  always_comb begin
    res = '0;
    res.queued_total = 8'(waiting_after);
    res.active_total = running;
    res.idle = (waiting_after == '0) && (running == 4'd0);
    case (req.cmd)
      CMD_SUBMIT: begin
        res.status = status_r;
        if (status_r != ST_EMPTY) res.queue_used = 3'(q);
      end
      CMD_TAKE: begin
        if (granted_ok) begin
          res.status         = ST_OK;
          res.granted_handle = ram_rdata;
          res.queue_used     = 3'(q);
          res.was_stolen     = stolen;
        end else begin
          res.status = (stopping && waiting == '0) ? ST_EXIT : ST_NONE;
        end
      end
      default: res.status = ST_OK;
    endcase
  end

  assign result = res;
endmodule

// File: rtl/wsts_ram.sv
// generic single port ram with registered read
`timescale 1ns / 1ps
module wsts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// File: bench/work_stealing_task_scheduler_test.sv
// testbench for the work stealing task scheduler: random and directed commands against a predictor
`timescale 1ns / 1ps
module work_stealing_task_scheduler_test;
  import wsts_pkg::*;

  localparam int NW = 8;
  localparam int QD = 16;

  // scoreboard: keeps a copy of the scheduler state and the expected responses
  class sched_scoreboard;
    logic [31:0] jobs [NW][QD];
    int unsigned head [NW];
    int unsigned fill [NW];
    int unsigned rr_next;
    int unsigned queued;
    int unsigned active;
    bit stopping;
    int unsigned lanes_reg;
    sched_out_t pending[$];
    int errors;
    int checked;
    int steals;
    int exits;

    function void clear();
      for (int i = 0; i < NW; i++) begin
        head[i] = 0;
        fill[i] = 0;
      end
      rr_next = 0;
      queued = 0;
      active = 0;
      stopping = 0;
      lanes_reg = 8;
      errors = 0;
      checked = 0;
      steals = 0;
      exits = 0;
    endfunction

    function int unsigned lanes();
      if (lanes_reg == 0) return 1;
      if (lanes_reg > NW) return NW;
      return lanes_reg;
    endfunction

    function void note_command(sched_in_t c);
      sched_out_t r;
      int unsigned n, q, v;
      bit got;
      n = lanes();
      r = '0;
      r.status = ST_OK;
      got = 0;
      case (cmd_t'(c.cmd))
        CMD_SUBMIT: begin
          if (c.task_handle == 0) begin
            r.status = ST_EMPTY;
          end else begin
            if (c.from_worker && c.worker < n) begin
              q = c.worker;
            end else begin
              q = (rr_next < n) ? rr_next : 0;
              rr_next = (q + 1 >= n) ? 0 : q + 1;
            end
            r.queue_used = q;
            if (stopping) begin
              r.status = ST_STOPPING;
            end else if (fill[q] >= QD) begin
              r.status = ST_FULL;
            end else begin
              jobs[q][(head[q] + fill[q]) % QD] = c.task_handle;
              fill[q]++;
              queued++;
            end
          end
        end
        CMD_TAKE: begin
          if (c.worker < n) begin
            if (fill[c.worker] > 0) begin
              fill[c.worker]--;
              r.granted_handle = jobs[c.worker][(head[c.worker] + fill[c.worker]) % QD];
              r.queue_used = c.worker;
              got = 1;
            end else begin
              for (int off = 1; off < n && !got; off++) begin
                v = (c.worker + off) % n;
                if (fill[v] > 0) begin
                  r.granted_handle = jobs[v][head[v]];
                  head[v] = (head[v] + 1) % QD;
                  fill[v]--;
                  r.queue_used = v;
                  r.was_stolen = 1;
                  got = 1;
                  steals++;
                end
              end
            end
          end
          if (got) begin
            if (active < RUN_MAX) active++;
            if (queued > 0) queued--;
          end else begin
            r.status = (stopping && queued == 0) ? ST_EXIT : ST_NONE;
            if (r.status == ST_EXIT) exits++;
          end
        end
        CMD_COMPLETE: begin
          if (active > 0) active--;
        end
        default: stopping = 1;
      endcase
      r.queued_total = queued;
      r.active_total = active;
      r.idle = (queued == 0 && active == 0);
      pending.insert(pending.size(), r);
    endfunction

    function void check_response(sched_out_t got);
      sched_out_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected response, expected none, actual %p", $time, got);
        errors++;
        return;
      end
      e = pending[0];
      pending.delete(0);
      checked++;
      if (got.status !== e.status)
        $display("%0t: status expected %0d actual %0d", $time, e.status, got.status);
      if (got.granted_handle !== e.granted_handle)
        $display("%0t: granted_handle expected %h actual %h", $time, e.granted_handle,
                 got.granted_handle);
      if (got.queue_used !== e.queue_used)
        $display("%0t: queue_used expected %0d actual %0d", $time, e.queue_used, got.queue_used);
      if (got.was_stolen !== e.was_stolen)
        $display("%0t: was_stolen expected %0d actual %0d", $time, e.was_stolen, got.was_stolen);
      if (got.queued_total !== e.queued_total)
        $display("%0t: queued_total expected %0d actual %0d", $time, e.queued_total,
                 got.queued_total);
      if (got.active_total !== e.active_total)
        $display("%0t: active_total expected %0d actual %0d", $time, e.active_total,
                 got.active_total);
      if (got.idle !== e.idle)
        $display("%0t: idle expected %0d actual %0d", $time, e.idle, got.idle);
      if (got !== e) errors++;
    endfunction
  endclass

  logic clk;
  logic rst;
  logic start;
  sched_in_t cmd_in;
  logic busy;
  logic done;
  sched_out_t result;
  logic cfg_we;
  logic [3:0] cfg_data;

  sched_scoreboard sb;
  int sent;

  work_stealing_task_scheduler u_dut (
    .clk(clk), .rst(rst), .start(start), .cmd_in(cmd_in), .busy(busy),
    .done(done), .result(result), .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("work_stealing_task_scheduler regression: fail");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check_response(result);
  end

  // one transaction: optional gap with start low, then hold start until accepted;
  // start stays high afterwards until the next gap or drain lowers it
  task automatic send(cmd_t c, logic [31:0] h, logic fw, logic [2:0] w, bit gaps);
    sched_in_t item;
    int unsigned gap;
    item.cmd = c;
    item.task_handle = h;
    item.from_worker = fw;
    item.worker = w;
    gap = gaps ? $urandom_range(0, 17) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      cmd_in <= sched_in_t'($urandom);
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd_in <= item;
    @(posedge clk iff !busy);
    sb.note_command(item);
    sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic set_lanes(logic [3:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.lanes_reg = v;
  endtask

  function automatic logic [31:0] rand_handle();
    logic [31:0] h;
    h = $urandom;
    case ($urandom_range(0, 7))
      0: h = 32'hFFFF_FFFF;
      1: h = 32'd1;
      2: h = 32'd0;
      default: ;
    endcase
    return h;
  endfunction

  // mostly submits and takes, with fewer completes and, when allow_stop is set, stops near the end
  task automatic random_phase(int count, bit allow_stop);
    int unsigned p;
    for (int i = 0; i < count; i++) begin
      p = $urandom_range(0, 99);
      if (allow_stop && i > count - 40 && p < 3)
        send(CMD_STOP, $urandom, $urandom, $urandom, 1);
      else if (p < 45)
        send(CMD_SUBMIT, rand_handle(), $urandom, $urandom, 1);
      else if (p < 80)
        send(CMD_TAKE, $urandom, $urandom, $urandom, 1);
      else
        send(CMD_COMPLETE, $urandom, $urandom, $urandom, 1);
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    sent = 0;
    rst = 1'b1;
    start = 1'b0;
    cmd_in = '0;
    cfg_we = 1'b0;
    cfg_data = 4'd8;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty job, own push/pop, full queue and steal
    send(CMD_SUBMIT, 32'd0, 1'b1, 3'd0, 0);
    send(CMD_TAKE, 32'd0, 1'b0, 3'd7, 0);
    send(CMD_SUBMIT, 32'hFFFF_FFFF, 1'b1, 3'd7, 0);
    send(CMD_SUBMIT, 32'h0000_0001, 1'b0, 3'd0, 0);
    for (int i = 0; i < 17; i++) send(CMD_SUBMIT, 32'h100 + i, 1'b1, 3'd2, 0);
    send(CMD_TAKE, 32'd0, 1'b0, 3'd1, 0);
    send(CMD_TAKE, 32'd0, 1'b0, 3'd2, 0);
    send(CMD_COMPLETE, 32'd0, 1'b0, 3'd5, 0);

    set_lanes(4'd1);
    random_phase(200, 0);
    set_lanes(4'd0);
    random_phase(60, 0);
    set_lanes(4'd15);
    random_phase(180, 0);
    for (int i = 0; i < 40; i++) send(CMD_COMPLETE, 32'd0, 1'b0, $urandom, 1);
    set_lanes(4'd3);
    random_phase(200, 0);
    set_lanes(4'd8);
    random_phase(180, 1);
    send(CMD_STOP, 32'd0, 1'b0, 3'd0, 1);
    send(CMD_STOP, 32'd0, 1'b0, 3'd0, 1);
    send(CMD_SUBMIT, 32'h55, 1'b1, 3'd0, 1);
    for (int i = 0; i < 140; i++) send(CMD_TAKE, 32'd0, 1'b0, $urandom, 1);
    for (int i = 0; i < 20; i++) send(CMD_COMPLETE, 32'd0, 1'b0, $urandom, 1);

    drain();
    $display("covered %0d commands, %0d responses, %0d steals, %0d worker exits",
             sent, sb.checked, sb.steals, sb.exits);
    $display("worker counts 0, 1, 3, 8 and 15 exercised, stop near the end of the run");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("work_stealing_task_scheduler regression: pass");
    end else begin
      $display("work_stealing_task_scheduler regression: fail");
    end
    $finish;
  end
endmodule
